// ----- rtl/preemptive_priority_scheduler_core_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; files that assert include it and provide clk_i and rst_ni.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ----- rtl/pps_pkg.sv -----
// Shared types and constants of the preemptive priority scheduler.
// Depends on nothing; used by the interfaces, the cell and the top level.
package pps_pkg;

  localparam int MaxProcsDef = 16;
  localparam int TimeW       = 16;
  localparam int PrioW       = 8;
  localparam int SlotFieldW  = 4;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  // Operation codes of an input word.
  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  // Broadcast write of one process slot.
  typedef struct packed {
    logic                  en;
    logic [SlotFieldW-1:0] slot;
    logic [TimeW-1:0]      arrival;
    logic [TimeW-1:0]      burst;
    logic [PrioW-1:0]      prio;
  } load_t;

  // Best ready candidate handed from cell to cell.
  typedef struct packed {
    logic             found;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] arrive;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] left;
  } cand_t;

endpackage

// ----- rtl/pps_if.sv -----
// Valid/ready channel interfaces for the scheduler input and result words.
// Depends on pps_pkg for field widths.
interface pps_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [pps_pkg::SlotFieldW-1:0] slot;
  logic [pps_pkg::TimeW-1:0]      arrival;
  logic [pps_pkg::TimeW-1:0]      burst;
  logic [pps_pkg::PrioW-1:0]      prio;

  modport source (output valid, op, slot, arrival, burst, prio, input ready);
  modport sink   (input valid, op, slot, arrival, burst, prio, output ready);
endinterface

interface pps_out_if;
  logic                          valid;
  logic                          ready;
  logic [pps_pkg::TimeW-1:0]      tick_time;
  logic                          idle;
  logic [pps_pkg::SlotFieldW-1:0] running_slot;
  logic                          finished;
  logic [pps_pkg::TimeW-1:0]      turnaround;
  logic [pps_pkg::TimeW-1:0]      waiting;
  logic                          time_saturated;

  modport source (output valid, tick_time, idle, running_slot, finished, turnaround,
                  waiting, time_saturated, input ready);
  modport sink   (input valid, tick_time, idle, running_slot, finished, turnaround,
                  waiting, time_saturated, output ready);
endinterface

// ----- rtl/preemptive_priority_scheduler_core.sv -----
// Preemptive priority scheduler: a load word writes one process slot. A tick word is
// accepted first; then the best ready candidate moves through the chain of slot cells
// one cell per cycle during the scan, and a commit step decrements the chosen slot, if
// any, advances time and writes the result word. The commit waits while an earlier
// result word is not taken.
// Depends on pps_pkg, pps_if, pps_cell and the assertion macro header.
`include "preemptive_priority_scheduler_core_macros.svh"

module preemptive_priority_scheduler_core #(
  parameter int MAX_PROCS = pps_pkg::MaxProcsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pps_in_if.sink        in_i,
  pps_out_if.source     out_o
);

  localparam int SlotW = $clog2(MAX_PROCS);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [SlotW-1:0]            cnt_q, cnt_d;
  logic [pps_pkg::TimeW-1:0]   now_q, now_d;
  logic                        in_fire;
  logic                        commit;
  pps_pkg::load_t              load;
  pps_pkg::cand_t              chain [MAX_PROCS+1];
  logic [SlotW-1:0]            chain_idx [MAX_PROCS+1];
  pps_pkg::cand_t              best;
  logic [SlotW-1:0]            best_idx;
  logic [pps_pkg::TimeW-1:0]   next_time;
  logic [pps_pkg::TimeW-1:0]   ta;
  logic                        fin;
  logic                        pick_ok;

  logic                          out_valid_q;
  logic [pps_pkg::TimeW-1:0]     tick_time_q;
  logic                          idle_q;
  logic [pps_pkg::SlotFieldW-1:0] running_slot_q;
  logic                          finished_q;
  logic [pps_pkg::TimeW-1:0]     turnaround_q;
  logic [pps_pkg::TimeW-1:0]     waiting_q;
  logic                          time_saturated_q;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign commit     = (state_q == StCommit) && (!out_valid_q || out_o.ready);

  // Load words are broadcast to all cells as soon as they are accepted.
  assign load.en      = in_fire && (in_i.op == pps_pkg::OpLoad);
  assign load.slot    = in_i.slot;
  assign load.arrival = in_i.arrival;
  assign load.burst   = in_i.burst;
  assign load.prio    = in_i.prio;

  // Chain of slot cells; the head sees no candidate.
  assign chain[0]     = '0;
  assign chain_idx[0] = '0;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    pps_cell #(
      .Idx   (g),
      .SlotW (SlotW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (load),
      .dec_i      (commit && best.found),
      .dec_idx_i  (best_idx),
      .now_i      (now_q),
      .cand_i     (chain[g]),
      .cand_idx_i (chain_idx[g]),
      .cand_o     (chain[g+1]),
      .cand_idx_o (chain_idx[g+1])
    );
  end

  assign best     = chain[MAX_PROCS];
  assign best_idx = chain_idx[MAX_PROCS];

  // Sequencer: wait for the scan to settle through every cell, then commit.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire && (in_i.op == pps_pkg::OpTick)) begin
          state_d = StScan;
          cnt_d   = '0;
        end
      end
      StScan: begin
        cnt_d = cnt_q + SlotW'(1);
        if (cnt_q == SlotW'(MAX_PROCS - 1)) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (commit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Time saturates at its maximum; completion is the end of the tick.
  always_comb begin
    next_time = (now_q == pps_pkg::TimeMax) ? now_q : now_q + pps_pkg::TimeW'(1);
    ta        = next_time - best.arrive;
    fin       = best.found && (best.left == pps_pkg::TimeW'(1));
    now_d     = commit ? next_time : now_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      now_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      now_q   <= now_d;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      tick_time_q      <= now_q;
      idle_q           <= !best.found;
      running_slot_q   <= best.found ? pps_pkg::SlotFieldW'(best_idx) : '0;
      finished_q       <= fin;
      turnaround_q     <= fin ? ta : '0;
      waiting_q        <= (fin && (ta >= best.burst)) ? ta - best.burst : '0;
      time_saturated_q <= (next_time == pps_pkg::TimeMax);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.tick_time      = tick_time_q;
  assign out_o.idle           = idle_q;
  assign out_o.running_slot   = running_slot_q;
  assign out_o.finished       = finished_q;
  assign out_o.turnaround     = turnaround_q;
  assign out_o.waiting        = waiting_q;
  assign out_o.time_saturated = time_saturated_q;

  // The winning candidate still has work and has already arrived.
  assign pick_ok = (best.left != '0) && (best.arrive <= now_q);

  // The chosen slot must really be ready at the current time.
  `PPS_ASSERT_NOW(a_pick_ready, (state_q == StCommit) && best.found, pick_ok)
  // Time moves only in the commit cycle.
  `PPS_ASSERT_NEXT(a_time_hold, state_q != StCommit, $stable(now_q))
  // Saturated time never wraps.
  `PPS_ASSERT_NEXT(a_time_sat, now_q == pps_pkg::TimeMax, now_q == pps_pkg::TimeMax)
  // A finished report always names a served slot.
  `PPS_ASSERT_NOW(a_fin_busy, out_valid_q && finished_q, !idle_q)

endmodule

// ----- rtl/pps_cell.sv -----
// One process slot of the scheduler chain: slot state plus one stage of the scan.
// Depends on pps_pkg for the load and candidate structs.
module pps_cell #(
  parameter int Idx   = 0,
  parameter int SlotW = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pps_pkg::load_t                load_i,
  input  logic                          dec_i,
  input  logic [SlotW-1:0]              dec_idx_i,
  input  logic [pps_pkg::TimeW-1:0]     now_i,
  input  pps_pkg::cand_t                cand_i,
  input  logic [SlotW-1:0]              cand_idx_i,
  output pps_pkg::cand_t                cand_o,
  output logic [SlotW-1:0]              cand_idx_o
);

  logic                          valid_q;
  logic [pps_pkg::TimeW-1:0]     arrive_q;
  logic [pps_pkg::TimeW-1:0]     burst_q;
  logic [pps_pkg::TimeW-1:0]     left_q;
  logic [pps_pkg::PrioW-1:0]     prio_q;
  logic                          load_hit;
  logic                          dec_hit;
  logic                          own_ready;
  logic                          take_own;
  pps_pkg::cand_t                cand_d, cand_q;
  logic [SlotW-1:0]              cand_idx_d, cand_idx_q;

  // A slot index that no cell owns simply finds no match.
  assign load_hit = load_i.en && (32'(load_i.slot) == Idx);
  assign dec_hit  = dec_i && (dec_idx_i == SlotW'(Idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_hit) begin
      valid_q <= 1'b1;
    end
  end

  // Slot contents; a load restarts the remaining work at the new burst.
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      arrive_q <= load_i.arrival;
      burst_q  <= load_i.burst;
      left_q   <= load_i.burst;
      prio_q   <= load_i.prio;
    end else if (dec_hit) begin
      left_q <= left_q - pps_pkg::TimeW'(1);
    end
  end

  // The incoming candidate comes from a lower slot, so it keeps ties.
  always_comb begin
    own_ready = valid_q && (arrive_q <= now_i) && (left_q != '0);
    take_own  = own_ready && (!cand_i.found || (prio_q < cand_i.prio));
    if (take_own) begin
      cand_d.found  = 1'b1;
      cand_d.prio   = prio_q;
      cand_d.arrive = arrive_q;
      cand_d.burst  = burst_q;
      cand_d.left   = left_q;
      cand_idx_d    = SlotW'(Idx);
    end else begin
      cand_d     = cand_i;
      cand_idx_d = cand_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q     <= '0;
      cand_idx_q <= '0;
    end else begin
      cand_q     <= cand_d;
      cand_idx_q <= cand_idx_d;
    end
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = cand_idx_q;

endmodule
